>>> rtl/pvc_pkg.sv
package pvc_pkg;

  localparam int MaxTerms     = 8;
  localparam int PositionBits = 32;
  localparam int FieldBits    = 64;
  localparam int SlopBits     = 32;
  localparam int CfgDataBits  = 64;
  localparam int CfgIdxBits   = 3;

  localparam logic [CfgIdxBits-1:0] CFG_IN_ORDER     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_COMPAT_MODE  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SLOP_ENABLED = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_SLOP_LIMIT   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_QUERY_FIELDS = 3'd4;

  localparam logic [1:0] OUT_MATCH = 2'd0;
  localparam logic [1:0] OUT_ORDER = 2'd1;
  localparam logic [1:0] OUT_SLOP  = 2'd2;
  localparam logic [1:0] OUT_FIELD = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT,
    ST_ORDER,
    ST_SLOP,
    ST_FIELD,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic sort_step;
    logic walk_init;
    logic order_step;
    logic slop_step;
    logic field_step;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sort_done;
    logic walk_done;
    logic violation;
  } dp_status_t;

endpackage

>>> rtl/pvc_ctrl.sv
module pvc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last_term,
  input  logic               keep_order,
  input  logic               slop_enabled,
  output logic               busy,
  output pvc_pkg::dp_cmd_t   cmd,
  input  pvc_pkg::dp_status_t status
);
  import pvc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (start && last_term) begin
          state_next = keep_order ? ST_ORDER : ST_SORT;
        end
      end
      ST_SORT: begin
        if (status.sort_done) begin
          state_next = ST_ORDER;
        end
      end
      ST_ORDER: begin
        if (status.violation) begin
          state_next = ST_DONE;
        end else if (status.walk_done) begin
          state_next = slop_enabled ? ST_SLOP : ST_FIELD;
        end
      end
      ST_SLOP: begin
        if (status.violation) begin
          state_next = ST_DONE;
        end else if (status.walk_done) begin
          state_next = ST_FIELD;
        end
      end
      ST_FIELD: begin
        if (status.violation || status.walk_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_LOAD: begin
        busy          = 1'b0;
        cmd.load      = start;
        cmd.sort_init = start && last_term;
        cmd.walk_init = start && last_term;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.walk_init = status.sort_done;
      end
      ST_ORDER: begin
        cmd.order_step = 1'b1;
        cmd.walk_init  = status.walk_done;
      end
      ST_SLOP: begin
        cmd.slop_step = 1'b1;
        cmd.walk_init = status.walk_done;
      end
      ST_FIELD: cmd.field_step = 1'b1;
      ST_DONE:  cmd.emit       = 1'b1;
      default:  cmd            = '0;
    endcase
  end

endmodule

>>> rtl/pvc_datapath.sv
module pvc_datapath #(
  parameter int MAX_TERMS     = pvc_pkg::MaxTerms,
  parameter int POSITION_BITS = pvc_pkg::PositionBits,
  parameter int FIELD_BITS    = pvc_pkg::FieldBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pvc_pkg::dp_cmd_t         cmd,
  output pvc_pkg::dp_status_t      status,
  input  logic [POSITION_BITS-1:0] term_start,
  input  logic [POSITION_BITS-1:0] term_end,
  input  logic [FIELD_BITS-1:0]    term_fields,
  input  logic                     keep_order,
  input  logic                     compat_mode,
  input  logic [pvc_pkg::SlopBits-1:0] slop_limit,
  input  logic [FIELD_BITS-1:0]    query_fields,
  output logic                     done,
  output logic [1:0]               outcome,
  output logic [2:0]               advance_index,
  output logic                     seek_valid,
  output logic [POSITION_BITS-1:0] seek_pos,
  output logic [POSITION_BITS-1:0] match_start,
  output logic [POSITION_BITS-1:0] match_end,
  output logic [FIELD_BITS-1:0]    match_fields
);
  import pvc_pkg::*;

  localparam int IdxBits = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CntBits = $clog2(MAX_TERMS + 1);

  logic [POSITION_BITS-1:0] start_store [MAX_TERMS];
  logic [POSITION_BITS-1:0] end_store   [MAX_TERMS];
  logic [FIELD_BITS-1:0]    field_store [MAX_TERMS];
  logic [IdxBits-1:0]       sorted_order [MAX_TERMS];
  logic [IdxBits-1:0]       sorted_order_next [MAX_TERMS];
  logic [CntBits-1:0]       term_count;
  logic [CntBits-1:0]       n;
  logic [CntBits-1:0]       pos;
  logic                     swapped;
  logic [SlopBits-1:0]      slop;
  logic [FIELD_BITS-1:0]    mask;
  logic [FIELD_BITS-1:0]    fields_and;
  logic                     ordered;
  logic                     compat;

  logic [IdxBits-1:0]       ia, ib, head_idx, last_idx;
  logic [POSITION_BITS-1:0] sa, sb, ea, tgt;
  logic                     bad;
  logic [POSITION_BITS:0]   gap;
  logic [SlopBits:0]        slop_sum;
  logic [FIELD_BITS-1:0]    mask_next;
  logic                     more;
  logic                     sort_swap [MAX_TERMS];
  logic                     any_swap;

  assign ordered = keep_order;
  assign compat  = keep_order && compat_mode;
  assign more    = (CntBits'(pos + 1'b1) < n);

  assign ia = ordered ? pos[IdxBits-1:0] : sorted_order[pos[IdxBits-1:0]];
  assign ib = ordered ? IdxBits'(pos + 1'b1)
                      : sorted_order[IdxBits'(pos + 1'b1)];
  assign sa = start_store[ia];
  assign sb = start_store[ib];
  assign ea = end_store[ia];
  assign bad = compat ? (sa > sb) : (ea >= sb);
  assign tgt = compat ? sa : ea;
  assign gap = ({1'b0, sb} > ({1'b0, sa} + 1'b1))
             ? ({1'b0, sb} - {1'b0, sa} - 1'b1) : '0;
  assign slop_sum = {1'b0, slop} + (SlopBits + 1)'(gap);
  assign mask_next = mask & field_store[pos[IdxBits-1:0]];
  assign head_idx = ordered ? '0 : sorted_order[0];
  assign last_idx  = ordered ? IdxBits'(n - 1'b1) : sorted_order[IdxBits'(n - 1'b1)];

  // odd-even transposition sort, stable: swap only on strictly greater
  always_comb begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      sorted_order_next[k] = sorted_order[k];
      sort_swap[k] = 1'b0;
    end
    for (int k = 0; k + 1 < MAX_TERMS; k++) begin
      if ((k[0] == pos[0]) && (CntBits'(k + 1) < n) &&
          (start_store[sorted_order[k]] > start_store[sorted_order[k + 1]])) begin
        sorted_order_next[k]     = sorted_order[k + 1];
        sorted_order_next[k + 1] = sorted_order[k];
        sort_swap[k] = 1'b1;
      end
    end
    any_swap = 1'b0;
    for (int k = 0; k < MAX_TERMS; k++) begin
      any_swap = any_swap | sort_swap[k];
    end
  end

  always_comb begin
    status = '0;
    status.sort_done  = (pos[0] == 1'b1) && !any_swap && !swapped;
    status.walk_done  = cmd.field_step ? !(CntBits'(pos + 1'b1) < n) : !more;
    status.violation  = (cmd.order_step && more && bad) ||
                        (cmd.slop_step && !more && (slop > slop_limit)) ||
                        (cmd.field_step && (mask_next == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        if (term_count < CntBits'(MAX_TERMS)) begin
          start_store[term_count[IdxBits-1:0]] <= term_start;
          end_store[term_count[IdxBits-1:0]]   <= term_end;
          field_store[term_count[IdxBits-1:0]] <= term_fields;
        end
        if (cmd.sort_init) begin
          n <= (term_count < CntBits'(MAX_TERMS)) ? CntBits'(term_count + 1'b1)
                                                 : term_count;
          term_count <= '0;
        end else if (term_count < CntBits'(MAX_TERMS)) begin
          term_count <= CntBits'(term_count + 1'b1);
        end
      end
      if (cmd.sort_init) begin
        for (int k = 0; k < MAX_TERMS; k++) begin
          sorted_order[k] <= IdxBits'(k);
        end
        pos        <= '0;
        swapped    <= 1'b1;
        outcome    <= OUT_MATCH;
        seek_valid <= 1'b0;
        seek_pos   <= '0;
        slop       <= '0;
        mask       <= query_fields;
        fields_and <= '1;
      end
      if (cmd.sort_step) begin
        sorted_order <= sorted_order_next;
        if (!cmd.walk_init) begin
          pos[0] <= ~pos[0];
        end
        // a pass pair is clean only when both phases swap nothing
        swapped <= (pos[0] == 1'b0) ? any_swap : 1'b0;
      end
      if (cmd.walk_init && !cmd.sort_init) begin
        pos <= '0;
      end
      if (cmd.order_step && more) begin
        if (bad) begin
          outcome       <= OUT_ORDER;
          advance_index <= 3'(ib);
          seek_valid    <= (tgt > sb);
          seek_pos      <= (tgt > sb) ? tgt : '0;
        end else begin
          pos <= CntBits'(pos + 1'b1);
        end
      end
      if (cmd.slop_step) begin
        if (more) begin
          slop <= slop_sum[SlopBits] ? '1 : slop_sum[SlopBits-1:0];
          pos  <= CntBits'(pos + 1'b1);
        end else if (slop > slop_limit) begin
          outcome       <= OUT_SLOP;
          advance_index <= 3'(head_idx);
        end
      end
      if (cmd.field_step) begin
        mask       <= mask_next;
        fields_and <= fields_and & field_store[pos[IdxBits-1:0]];
        pos        <= CntBits'(pos + 1'b1);
        if (mask_next == '0) begin
          outcome       <= OUT_FIELD;
          advance_index <= 3'(pos);
        end
      end
      if (cmd.emit) begin
        done <= 1'b1;
        if (outcome == OUT_MATCH) begin
          advance_index <= 3'(head_idx);
          match_start   <= start_store[head_idx];
          match_end     <= end_store[last_idx];
          match_fields  <= fields_and;
        end else begin
          match_start  <= '0;
          match_end    <= '0;
          match_fields <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/proximity_violation_check.sv
// proximity_violation_check: proximity match test over one combination of terms.
// Throughput: one term word per cycle while loading; busy stays high from the
// last term word of a combination until done, then the next word may enter.
// Sequence: after the last term word the controller sorts (unordered only), walks the
// terms for order, then for slop (skipped when disabled), then for fields, and then
// raises done; a violation cuts the walks short. The receiver
// cannot stall. Reset clears the term count, the controller and the config.
module proximity_violation_check #(
  parameter int MAX_TERMS     = pvc_pkg::MaxTerms,
  parameter int POSITION_BITS = pvc_pkg::PositionBits,
  parameter int FIELD_BITS    = pvc_pkg::FieldBits
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [POSITION_BITS-1:0] term_start,
  input  logic [POSITION_BITS-1:0] term_end,
  input  logic [FIELD_BITS-1:0]    term_fields,
  input  logic                     last_term,
  // config write port
  input  logic                     cfg_we,
  input  logic [pvc_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [pvc_pkg::CfgDataBits-1:0] cfg_data,
  // result word
  output logic                     done,
  output logic [1:0]               outcome,
  output logic [2:0]               advance_index,
  output logic                     seek_valid,
  output logic [POSITION_BITS-1:0] seek_pos,
  output logic [POSITION_BITS-1:0] match_start,
  output logic [POSITION_BITS-1:0] match_end,
  output logic [FIELD_BITS-1:0]    match_fields
);
  import pvc_pkg::*;

  logic                  keep_order;
  logic                  compat_mode;
  logic                  slop_enabled;
  logic [SlopBits-1:0]   slop_limit;
  logic [FIELD_BITS-1:0] query_fields;
  dp_cmd_t               cmd;
  dp_status_t            status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_order   <= 1'b0;
      compat_mode  <= 1'b0;
      slop_enabled <= 1'b0;
      slop_limit   <= '0;
      query_fields <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_ORDER:     keep_order   <= cfg_data[0];
        CFG_COMPAT_MODE:  compat_mode  <= cfg_data[0];
        CFG_SLOP_ENABLED: slop_enabled <= cfg_data[0];
        CFG_SLOP_LIMIT:   slop_limit   <= cfg_data[SlopBits-1:0];
        CFG_QUERY_FIELDS: query_fields <= cfg_data[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  pvc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_term    (last_term),
    .keep_order   (keep_order),
    .slop_enabled (slop_enabled),
    .busy         (busy),
    .cmd          (cmd),
    .status       (status)
  );

  pvc_datapath #(
    .MAX_TERMS     (MAX_TERMS),
    .POSITION_BITS (POSITION_BITS),
    .FIELD_BITS    (FIELD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .term_start    (term_start),
    .term_end      (term_end),
    .term_fields   (term_fields),
    .keep_order    (keep_order),
    .compat_mode   (compat_mode),
    .slop_limit    (slop_limit),
    .query_fields  (query_fields),
    .done          (done),
    .outcome       (outcome),
    .advance_index (advance_index),
    .seek_valid    (seek_valid),
    .seek_pos      (seek_pos),
    .match_start   (match_start),
    .match_end     (match_end),
    .match_fields  (match_fields)
  );

endmodule
